FILE: design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the route lookup block
// Table geometry, result status codes and the packed route table entry.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int TABLE_DEPTH     = 32;
  localparam int INTERFACE_COUNT = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_FORWARDED   = 3'd0;
  localparam logic [2:0] ST_TTL_EXPIRED = 3'd1;
  localparam logic [2:0] ST_NO_ROUTE    = 3'd2;
  localparam logic [2:0] ST_ADDED       = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic        has_hop;
    logic [31:0] hop;
    logic [3:0]  iface;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/longest_prefix_route_lookup.sv
// An add or an expired-TTL datagram goes from S_IDLE to S_FINISH and on to the
// output register; a lookup first scans every stored route in S_SCAN, if any.
// New input is taken only in S_IDLE, so a request ends before the next starts;
// the single table read port and the one prefix comparator walk every stored
// route, one entry per cycle. Output stalls hold the result in S_FINISH.
// Reset (synchronous, active low) clears count, state, out valid; no table pass.
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup: IPv4 longest prefix match routing table
// Appends routes and resolves datagram destinations by a sequential scan.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] prefix, [37:32] prefix length, [38] has_next_hop,
  // [70:39] next_hop_address, [74:71] interface_index,
  // [106:75] destination_address, [114:107] time_to_live, [119:115] zero
  input  logic [119:0] in_tdata,
  // [0] operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] out_interface, [35:4] hop_address, [43:36] new_ttl, [47:44] zero
  output logic [47:0]  out_tdata,
  // [2:0] status
  output logic [2:0]   out_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                   state_r;
  logic [lpr_pkg::CNT_W-1:0] count_r;
  logic [lpr_pkg::IDX_W-1:0] scan_idx_r;
  logic                     lookup_r;
  logic [2:0]               res_status_r;
  logic [31:0]              dst_r;
  logic [7:0]               ttl_r;
  logic                     found_r;
  logic [5:0]               best_len_r;
  logic                     best_has_hop_r;
  logic [31:0]              best_hop_r;
  logic [3:0]               best_iface_r;

  logic                     out_tvalid_r;
  logic [2:0]               out_status_r;
  logic [3:0]               out_iface_r;
  logic [31:0]              out_hop_r;
  logic [7:0]               out_ttl_r;

  // input fields
  logic [31:0] in_prefix;
  logic [5:0]  in_plen;
  logic        in_has_hop;
  logic [31:0] in_hop;
  logic [3:0]  in_iface;
  logic [31:0] in_dst;
  logic [7:0]  in_ttl;

  assign in_prefix  = in_tdata[31:0];
  assign in_plen    = in_tdata[37:32];
  assign in_has_hop = in_tdata[38];
  assign in_hop     = in_tdata[70:39];
  assign in_iface   = in_tdata[74:71];
  assign in_dst     = in_tdata[106:75];
  assign in_ttl     = in_tdata[114:107];

  logic in_fire;
  logic table_full;
  logic ram_we;
  logic [lpr_pkg::IDX_W-1:0] ram_raddr;
  lpr_pkg::entry_t wr_entry;
  lpr_pkg::entry_t rd_entry;
  logic [lpr_pkg::ENTRY_W-1:0] rd_bits;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign table_full = (count_r == lpr_pkg::CNT_W'(lpr_pkg::TABLE_DEPTH));
  assign ram_we     = in_fire && (in_tuser == lpr_pkg::OP_ADD) && !table_full;

  always_comb begin
    wr_entry.prefix  = in_prefix;
    wr_entry.length  = (in_plen > 6'd32) ? 6'd32 : in_plen;
    wr_entry.has_hop = in_has_hop;
    wr_entry.hop     = in_hop;
    wr_entry.iface   = in_iface;
  end

  // Prefetch entry zero while idle, then the entry after the one on rdata.
  assign ram_raddr = (state_r == S_IDLE) ? '0 : scan_idx_r + lpr_pkg::IDX_W'(1);

  lpr_ram #(
    .WIDTH (lpr_pkg::ENTRY_W),
    .DEPTH (lpr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[lpr_pkg::IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  assign rd_entry = lpr_pkg::entry_t'(rd_bits);

  // shared compare unit: masked prefix match plus length priority
  logic [31:0] mask;
  logic        hit;
  logic        take;
  logic        scan_last;

  assign mask = (rd_entry.length == 6'd0) ? 32'h0 :
                (32'hFFFF_FFFF << (6'd32 - rd_entry.length));
  assign hit  = ((dst_r & mask) == (rd_entry.prefix & mask));
  assign take = hit && (!found_r || (rd_entry.length > best_len_r));
  assign scan_last = ((lpr_pkg::CNT_W'(scan_idx_r) + lpr_pkg::CNT_W'(1)) == count_r);

  logic out_free;
  logic iface_ok;
  assign out_free = !out_tvalid_r || out_tready;
  assign iface_ok = (32'(best_iface_r) < 32'(lpr_pkg::INTERFACE_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_FINISH)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            dst_r      <= in_dst;
            ttl_r      <= in_ttl;
            found_r    <= 1'b0;
            scan_idx_r <= '0;
            if (in_tuser == lpr_pkg::OP_ADD) begin
              lookup_r <= 1'b0;
              state_r  <= S_FINISH;
              if (table_full) begin
                res_status_r <= lpr_pkg::ST_FULL;
              end else begin
                res_status_r <= lpr_pkg::ST_ADDED;
                count_r      <= count_r + lpr_pkg::CNT_W'(1);
              end
            end else if (in_ttl <= 8'd1) begin
              lookup_r     <= 1'b0;
              state_r      <= S_FINISH;
              res_status_r <= lpr_pkg::ST_TTL_EXPIRED;
            end else begin
              lookup_r <= 1'b1;
              if (count_r != '0) begin
                state_r <= S_SCAN;
              end else begin
                state_r <= S_FINISH;
              end
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            found_r        <= 1'b1;
            best_len_r     <= rd_entry.length;
            best_has_hop_r <= rd_entry.has_hop;
            best_hop_r     <= rd_entry.hop;
            best_iface_r   <= rd_entry.iface;
          end
          if (scan_last) begin
            state_r <= S_FINISH;
          end else begin
            scan_idx_r <= scan_idx_r + lpr_pkg::IDX_W'(1);
          end
        end
        S_FINISH: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            if (!lookup_r) begin
              out_status_r <= res_status_r;
              out_iface_r  <= 4'd0;
              out_hop_r    <= 32'd0;
              out_ttl_r    <= 8'd0;
            end else if (found_r && iface_ok) begin
              out_status_r <= lpr_pkg::ST_FORWARDED;
              out_iface_r  <= best_iface_r;
              out_hop_r    <= best_has_hop_r ? best_hop_r : dst_r;
              out_ttl_r    <= ttl_r - 8'd1;
            end else begin
              out_status_r <= lpr_pkg::ST_NO_ROUTE;
              out_iface_r  <= 4'd0;
              out_hop_r    <= 32'd0;
              out_ttl_r    <= 8'd0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_ttl_r, out_hop_r, out_iface_r};
  assign out_tuser  = out_status_r;

endmodule

FILE: design/lpr_ram.sv
// ----------------------------------------------------------------------------
// lpr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: dv/longest_prefix_route_lookup_tb.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_tb: self-checking bench for the route lookup
// Streams route adds and datagram lookups through the block with random
// idle gaps on both sides, predicts every result from a shadow forwarding
// table kept here, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_tb;

  typedef struct {
    logic        op;
    logic [31:0] prefix;
    logic [5:0]  plen;
    logic        has_hop;
    logic [31:0] hop;
    logic [3:0]  ifc;
    logic [31:0] dst;
    logic [7:0]  ttl;
    bit          drain;  // hold this item until every result is back
  } route_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  iface;
    logic [31:0] hop;
    logic [7:0]  ttl;
  } route_result_t;

  typedef struct {
    logic [31:0] prefix;
    logic [5:0]  len;
  } known_route_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [2:0]   out_tuser;

  longest_prefix_route_lookup DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Shadow forwarding table
  logic [31:0] fib_prefix [lpr_pkg::TABLE_DEPTH];
  logic [5:0]  fib_len    [lpr_pkg::TABLE_DEPTH];
  logic        fib_has_hop[lpr_pkg::TABLE_DEPTH];
  logic [31:0] fib_hop    [lpr_pkg::TABLE_DEPTH];
  logic [3:0]  fib_iface  [lpr_pkg::TABLE_DEPTH];
  int          fib_count = 0;

  route_item_t   pending_items[$];
  route_result_t awaited_results[$];
  known_route_t  gen_routes[$];
  logic [31:0]   net_bases[8];

  route_item_t cur_item;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_cnt = 0;

  function automatic logic [31:0] prefix_mask(logic [5:0] len);
    return (len == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic route_result_t compute_route_result(route_item_t it);
    route_result_t r;
    logic [31:0]   m;
    bit            hit;
    int            best;
    r = '{status: lpr_pkg::ST_NO_ROUTE, iface: '0, hop: '0, ttl: '0};
    hit = 0;
    best = 0;
    if (it.op == lpr_pkg::OP_ADD) begin
      if (fib_count < lpr_pkg::TABLE_DEPTH) begin
        fib_prefix[fib_count]  = it.prefix;
        fib_len[fib_count]     = (it.plen > 6'd32) ? 6'd32 : it.plen;
        fib_has_hop[fib_count] = it.has_hop;
        fib_hop[fib_count]     = it.hop;
        fib_iface[fib_count]   = it.ifc;
        fib_count++;
        r.status = lpr_pkg::ST_ADDED;
      end else begin
        r.status = lpr_pkg::ST_FULL;
      end
    end else if (it.ttl <= 8'd1) begin
      r.status = lpr_pkg::ST_TTL_EXPIRED;
    end else begin
      // longest match wins; strict compare keeps the earliest on a tie
      for (int i = 0; i < fib_count; i++) begin
        m = prefix_mask(fib_len[i]);
        if (((it.dst ^ fib_prefix[i]) & m) == 32'h0 &&
            (!hit || fib_len[i] > fib_len[best])) begin
          hit = 1;
          best = i;
        end
      end
      if (hit && fib_iface[best] < lpr_pkg::INTERFACE_COUNT) begin
        r.status = lpr_pkg::ST_FORWARDED;
        r.iface  = fib_iface[best];
        r.hop    = fib_has_hop[best] ? fib_hop[best] : it.dst;
        r.ttl    = it.ttl - 8'd1;
      end
    end
    return r;
  endfunction

  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_add(logic [31:0] prefix, logic [5:0] plen, logic has_hop,
                           logic [31:0] hop, logic [3:0] ifc, bit drain = 0);
    route_item_t it;
    it = '{op: lpr_pkg::OP_ADD, prefix: prefix, plen: plen, has_hop: has_hop, hop: hop,
           ifc: ifc, dst: $urandom, ttl: 8'($urandom), drain: drain};
    if (gen_routes.size() < lpr_pkg::TABLE_DEPTH)
      gen_routes.insert(gen_routes.size(),
                        '{prefix: prefix, len: (plen > 6'd32) ? 6'd32 : plen});
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_lookup(logic [31:0] dst, logic [7:0] ttl, bit drain = 0);
    route_item_t it;
    it = '{op: lpr_pkg::OP_ROUTE, prefix: $urandom, plen: 6'($urandom),
           has_hop: 1'($urandom), hop: $urandom, ifc: 4'($urandom), dst: dst, ttl: ttl,
           drain: drain};
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                recv_cnt, name, got, want));
  endtask

  task automatic build_directed();
    queue_lookup(32'h0102_0304, 8'd64);         // empty table
    queue_lookup(32'hFFFF_FFFF, 8'd0);          // TTL zero
    queue_lookup(32'h0000_0000, 8'd1);          // TTL one
    queue_add(32'hC0A8_0101, 6'd32, 1'b0, 32'h0, 4'd0);
    queue_lookup(32'hC0A8_0101, 8'd2);          // direct host route
    queue_lookup(32'hC0A8_0100, 8'd255);        // miss with a non-empty table
    queue_add(32'h0A00_0001, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15);  // overlong length
    queue_add(32'h0AFF_FFFF, 6'd8, 1'b1, 32'h0A00_00FE, 4'd5);    // junk below length
    queue_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_0001, 4'd6);    // loses the tie
    queue_add(32'h0A10_0000, 6'd12, 1'b0, 32'h0, 4'd9);
    queue_lookup(32'h0A12_3456, 8'd64);
    queue_lookup(32'h0A80_0000, 8'd64);
    queue_lookup(32'h0A00_0001, 8'd128);
    queue_lookup(32'h0A00_0002, 8'd1);
    queue_add(32'hFFFF_FFFF, 6'd0, 1'b1, 32'hC000_0001, 4'd3);    // default route
    queue_lookup(32'h0000_0000, 8'd255);
    queue_lookup(32'hFFFF_FFFF, 8'd2);
    queue_lookup(32'h0AFF_FFFF, 8'd200);
  endtask

  task automatic build_random(int count);
    int          r;
    int          k;
    logic [31:0] m;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [5:0]  len;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 4) begin
        r = $urandom_range(0, 99);
        if (r < 2) len = 6'd0;
        else if (r < 12) len = 6'($urandom_range(33, 63));
        else len = 6'($urandom_range(1, 32));
        // share high bits with a few base networks so routes nest
        queue_add(net_bases[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 32)),
                  len, 1'($urandom), $urandom, 4'($urandom), n == 500 || n == 1100);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65 && gen_routes.size() > 0) begin
          k = $urandom_range(0, gen_routes.size() - 1);
          m = prefix_mask(gen_routes[k].len);
          dst = (gen_routes[k].prefix & m) | ($urandom & ~m);
          if ($urandom_range(0, 3) == 0) dst ^= 32'h1 << $urandom_range(0, 31);
        end else if (r < 90) begin
          dst = net_bases[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 32));
        end else begin
          dst = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 4) ttl = 8'd0;
        else if (r < 8) ttl = 8'd1;
        else if (r < 12) ttl = 8'd255;
        else if (r < 16) ttl = 8'd2;
        else ttl = 8'($urandom_range(2, 255));
        queue_lookup(dst, ttl, n == 500 || n == 1100);
      end
    end
  endtask

  // Driver: present queued items, idle between transactions
  always @(posedge clk) begin : drive
    route_item_t nxt;
    bit          accept;
    int          sent_now;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
      sent_cnt  <= 0;
    end else begin
      accept = in_tvalid && in_tready;
      sent_now = sent_cnt + int'(accept);
      if (accept) begin
        awaited_results.insert(awaited_results.size(), compute_route_result(cur_item));
        sent_cnt <= sent_now;
      end
      if (!in_tvalid || accept) begin
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && sent_now != recv_cnt)) begin
          nxt = pending_items.pop_front();
          cur_item  <= nxt;
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.op;
          in_tdata  <= {5'b0, nxt.ttl, nxt.dst, nxt.ifc, nxt.hop, nxt.has_hop,
                        nxt.plen, nxt.prefix};
          // every fourth stretch of 64 items runs back to back
          gap_left  <= (((sent_now / 64) % 4) == 3) ? 0 : draw_idle();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin : observe
    route_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      recv_cnt   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        recv_cnt <= recv_cnt + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", recv_cnt));
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(out_tuser), 32'(want.status));
          check_field("out_interface", 32'(out_tdata[3:0]), 32'(want.iface));
          check_field("hop_address", out_tdata[35:4], want.hop);
          check_field("new_ttl", 32'(out_tdata[43:36]), 32'(want.ttl));
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if (((recv_cnt / 80) % 4) != 1 && $urandom_range(0, 99) < 20)
          stall_left <= draw_idle();
      end
    end
  end

  initial begin : sequencer
    foreach (net_bases[i]) net_bases[i] = $urandom;
    build_directed();
    build_random(1530);
    wait (rst_n === 1'b1);
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || sent_cnt != recv_cnt);
    // let any stray result show up
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("longest_prefix_route_lookup_tb: PASS");
    end else begin
      $display("longest_prefix_route_lookup_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("longest_prefix_route_lookup_tb: FAIL");
    $finish;
  end

endmodule
